// ----- rtl/sdft_pkg.sv -----
// Shared constants and types of the sliding DFT bin engine.
package sdft_pkg;

  parameter int BinsDef       = 64;
  parameter int SampleBitsDef = 16;
  parameter int FracBitsDef   = 16;

  parameter int BinBits  = 40;
  parameter int LoBits   = 20;
  parameter int HiBits   = BinBits - LoBits;
  parameter int OutBits  = 23;
  parameter int OutLimit = 2097152;
  parameter int IdxBits  = 6;
  parameter int AddrBits = 3;
  parameter int DataBits = 32;

  parameter longint HalfPiQ30 = 64'd1686629713;

  typedef enum logic {
    REG_OUTPUT_MODE = 1'b0,
    REG_TRACKED_BIN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                output_mode;
    logic [IdxBits-1:0]  tracked_bin;
  } cfg_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic adv;
    logic busy;
  } status_t;

endpackage

// ----- rtl/sdft_sample_if.sv -----
// Input channel carrying one signed sample per word.
interface sdft_sample_if #(
  parameter int SampleBits = sdft_pkg::SampleBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- rtl/sdft_result_if.sv -----
// Output channel carrying one reported bin per word.
interface sdft_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [sdft_pkg::IdxBits-1:0]         bin_index;
  logic signed [sdft_pkg::OutBits-1:0]  real_part;
  logic signed [sdft_pkg::OutBits-1:0]  imag_part;
  logic                                 last;

  modport source (output valid, output bin_index, output real_part, output imag_part,
                  output last, input ready);
  modport sink (input valid, input bin_index, input real_part, input imag_part,
                input last, output ready);
endinterface

// ----- rtl/sdft_regs.sv -----
// APB configuration registers with a clear strobe on every write.
module sdft_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdft_pkg::AddrBits-1:0]  paddr,
  input  logic [sdft_pkg::DataBits-1:0]  pwdata,
  output logic [sdft_pkg::DataBits-1:0]  prdata,
  output logic                           pready,
  output sdft_pkg::cfg_t                 cfg_o,
  output logic                           clear_o
);

  sdft_pkg::cfg_t     cfg_q, cfg_d;
  sdft_pkg::reg_idx_e sel;
  logic               wr;

  assign pready  = 1'b1;
  assign sel     = sdft_pkg::reg_idx_e'(paddr[2]);
  assign wr      = psel && penable && pwrite;
  assign clear_o = wr;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        sdft_pkg::REG_OUTPUT_MODE: cfg_d.output_mode = pwdata[0];
        sdft_pkg::REG_TRACKED_BIN: cfg_d.tracked_bin = pwdata[sdft_pkg::IdxBits-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      sdft_pkg::REG_OUTPUT_MODE: prdata = sdft_pkg::DataBits'(cfg_q.output_mode);
      sdft_pkg::REG_TRACKED_BIN: prdata = sdft_pkg::DataBits'(cfg_q.tracked_bin);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/sdft_twiddle_rom.sv -----
// Twiddle ROM: cosine and negated sine per bin, registered read.
module sdft_twiddle_rom #(
  parameter int Bins     = sdft_pkg::BinsDef,
  parameter int FracBits = sdft_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [$clog2(Bins)-1:0]       addr_i,
  output logic signed [FracBits+1:0]    re_o,
  output logic signed [FracBits+1:0]    im_o
);

  localparam int CoefW = FracBits + 2;
  localparam int TwW   = 2 * CoefW;

  function automatic logic [127:0] sincos_q30(longint x);
    longint x2, tc, ts, sc, ss;
    x2 = (x * x) >>> 30;
    tc = longint'(1) <<< 30;
    ts = x;
    sc = tc;
    ss = ts;
    tc = ((tc * x2) >>> 30) / 2;   ts = ((ts * x2) >>> 30) / 6;   sc = sc - tc; ss = ss - ts;
    tc = ((tc * x2) >>> 30) / 12;  ts = ((ts * x2) >>> 30) / 20;  sc = sc + tc; ss = ss + ts;
    tc = ((tc * x2) >>> 30) / 30;  ts = ((ts * x2) >>> 30) / 42;  sc = sc - tc; ss = ss - ts;
    tc = ((tc * x2) >>> 30) / 56;  ts = ((ts * x2) >>> 30) / 72;  sc = sc + tc; ss = ss + ts;
    tc = ((tc * x2) >>> 30) / 90;  ts = ((ts * x2) >>> 30) / 110; sc = sc - tc; ss = ss - ts;
    tc = ((tc * x2) >>> 30) / 132; ts = ((ts * x2) >>> 30) / 156; sc = sc + tc; ss = ss + ts;
    tc = ((tc * x2) >>> 30) / 182; ts = ((ts * x2) >>> 30) / 210; sc = sc - tc; ss = ss - ts;
    return {sc, ss};
  endfunction

  function automatic longint to_frac(longint v);
    longint w;
    w = (v < 0) ? longint'(0) : v;
    return (w + (longint'(1) <<< (29 - FracBits))) >>> (30 - FracBits);
  endfunction

  function automatic logic [Bins-1:0][TwW-1:0] build_table();
    logic [Bins-1:0][TwW-1:0] tbl;
    logic [127:0]             pr;
    longint                   r, q, rem, a, c0, s0, cr, sr, cs, ss;
    for (int k = 0; k < Bins; k++) begin
      r   = 4 * k;
      q   = r / Bins;
      rem = r - q * Bins;
      if (2 * rem <= Bins) begin
        a  = (sdft_pkg::HalfPiQ30 * rem) / Bins;
        pr = sincos_q30(a);
        c0 = pr[127:64];
        s0 = pr[63:0];
      end else begin
        a  = (sdft_pkg::HalfPiQ30 * (Bins - rem)) / Bins;
        pr = sincos_q30(a);
        s0 = pr[127:64];
        c0 = pr[63:0];
      end
      cr = to_frac(c0);
      sr = to_frac(s0);
      case (q & 3)
        0: begin cs = cr;  ss = sr;  end
        1: begin cs = -sr; ss = cr;  end
        2: begin cs = -cr; ss = -sr; end
        default: begin cs = sr; ss = -cr; end
      endcase
      tbl[k] = {CoefW'(cs), CoefW'(-ss)};
    end
    return tbl;
  endfunction

  localparam logic [Bins-1:0][TwW-1:0] TwTable = build_table();

  logic [TwW-1:0] tw_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tw_q <= TwTable[addr_i];
    end
  end

  assign re_o = tw_q[TwW-1:CoefW];
  assign im_o = tw_q[CoefW-1:0];

endmodule

// ----- rtl/sdft_datapath.sv -----
// Bin memory with the read, rotate and write-back pipeline and the result register.
module sdft_datapath #(
  parameter int Bins       = sdft_pkg::BinsDef,
  parameter int SampleBits = sdft_pkg::SampleBitsDef,
  parameter int FracBits   = sdft_pkg::FracBitsDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  sdft_pkg::cfg_t                            cfg_i,
  input  sdft_pkg::ctrl_t                           ctrl_i,
  input  logic [$clog2(Bins)-1:0]                   addr_i,
  input  logic signed [SampleBits+FracBits:0]       delta_i,
  output sdft_pkg::status_t                         status_o,
  sdft_result_if.source                             res_o
);

  localparam int KW      = $clog2(Bins);
  localparam int BW      = sdft_pkg::BinBits;
  localparam int LW      = sdft_pkg::LoBits;
  localparam int HW      = sdft_pkg::HiBits;
  localparam int CoefW   = FracBits + 2;
  localparam int DeltaW  = SampleBits + FracBits + 1;
  localparam int SumW    = ((DeltaW > BW) ? DeltaW : BW) + 1;
  localparam int PhW     = HW + CoefW;
  localparam int PlW     = LW + 1 + CoefW;
  localparam int HsW     = PhW + 1;
  localparam int LsW     = PlW + 2;
  localparam int TotW    = HsW + LW + 2;
  localparam int OsW     = BW + 1;

  localparam logic signed [SumW-1:0] SumMax = {{(SumW-BW+1){1'b0}}, {(BW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {{(SumW-BW+1){1'b1}}, {(BW-1){1'b0}}};
  localparam logic signed [TotW-1:0] TotMax = {{(TotW-BW+1){1'b0}}, {(BW-1){1'b1}}};
  localparam logic signed [TotW-1:0] TotMin = {{(TotW-BW+1){1'b1}}, {(BW-1){1'b0}}};
  localparam logic signed [LsW-1:0]  LsHalf = LsW'(1) <<< (FracBits - 1);
  localparam logic signed [OsW-1:0]  OsHalf = OsW'(1) <<< (FracBits - 1);
  localparam logic signed [OsW-1:0]  OsMax  = OsW'(sdft_pkg::OutLimit);
  localparam logic signed [OsW-1:0]  OsMin  = -OsMax;

  logic [2*BW-1:0] bin_mem [Bins];
  logic [2*BW-1:0] bin_rd_q;
  logic            adv, rd_en, wr_en, sel_out;
  logic [KW-1:0]   wr_addr, trk;
  logic [2*BW-1:0] wr_data;

  logic signed [CoefW-1:0] tw_re, tw_im;

  // read stage
  logic                   s1_valid_q;
  logic [KW-1:0]          s1_k_q;
  logic signed [BW-1:0]   br, bi, dr;
  logic signed [SumW-1:0] sum;

  // split stage
  logic                    s2_valid_q;
  logic [KW-1:0]           s2_k_q;
  logic signed [HW-1:0]    dh_r_q, dh_i_q;
  logic [LW-1:0]           dl_r_q, dl_i_q;
  logic signed [CoefW-1:0] c_q, s_q;

  // product stage
  logic                  s3_valid_q;
  logic [KW-1:0]         s3_k_q;
  logic signed [PhW-1:0] p_hrc_q, p_his_q, p_hrs_q, p_hic_q;
  logic signed [PlW-1:0] p_lrc_q, p_lis_q, p_lrs_q, p_lic_q;
  logic signed [HsW-1:0] hs_re, hs_im;
  logic signed [LsW-1:0] ls_re, ls_im;
  logic signed [TotW-1:0] tot_re, tot_im, sh_re, sh_im;
  logic signed [BW-1:0]  nre, nim;

  // write-back stage
  logic                 s4_valid_q;
  logic [KW-1:0]        s4_k_q;
  logic signed [BW-1:0] re_q, im_q;
  logic signed [OsW-1:0] os_re, os_im, oc_re, oc_im;

  // result register
  logic                                 out_valid_q;
  logic [sdft_pkg::IdxBits-1:0]         out_idx_q;
  logic signed [sdft_pkg::OutBits-1:0]  out_re_q, out_im_q;
  logic                                 out_last_q;

  assign adv   = !out_valid_q || res_o.ready;
  assign rd_en = adv && ctrl_i.issue;

  assign status_o.adv  = adv;
  assign status_o.busy = s1_valid_q || s2_valid_q || s3_valid_q || s4_valid_q;

  sdft_twiddle_rom #(
    .Bins     (Bins),
    .FracBits (FracBits)
  ) u_twiddle (
    .clk_i  (clk_i),
    .en_i   (rd_en),
    .addr_i (addr_i),
    .re_o   (tw_re),
    .im_o   (tw_im)
  );

  assign wr_en   = ctrl_i.clear || (adv && s4_valid_q);
  assign wr_addr = ctrl_i.clear ? addr_i : s4_k_q;
  assign wr_data = ctrl_i.clear ? '0 : {re_q, im_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      bin_rd_q <= bin_mem[addr_i];
    end
  end

  // add the sample difference to the real part and saturate
  always_comb begin
    br  = bin_rd_q[2*BW-1:BW];
    bi  = bin_rd_q[BW-1:0];
    sum = SumW'(br) + SumW'(delta_i);
    if (sum > SumMax) begin
      dr = SumMax[BW-1:0];
    end else if (sum < SumMin) begin
      dr = SumMin[BW-1:0];
    end else begin
      dr = sum[BW-1:0];
    end
  end

  // rotate: re = dr*c - di*s, im = dr*s + di*c, rounded half up and saturated
  always_comb begin
    hs_re  = HsW'(p_hrc_q) - HsW'(p_his_q);
    hs_im  = HsW'(p_hrs_q) + HsW'(p_hic_q);
    ls_re  = LsW'(p_lrc_q) - LsW'(p_lis_q) + LsHalf;
    ls_im  = LsW'(p_lrs_q) + LsW'(p_lic_q) + LsHalf;
    tot_re = (TotW'(hs_re) <<< LW) + TotW'(ls_re);
    tot_im = (TotW'(hs_im) <<< LW) + TotW'(ls_im);
    sh_re  = tot_re >>> FracBits;
    sh_im  = tot_im >>> FracBits;
    if (sh_re > TotMax) begin
      nre = TotMax[BW-1:0];
    end else if (sh_re < TotMin) begin
      nre = TotMin[BW-1:0];
    end else begin
      nre = sh_re[BW-1:0];
    end
    if (sh_im > TotMax) begin
      nim = TotMax[BW-1:0];
    end else if (sh_im < TotMin) begin
      nim = TotMin[BW-1:0];
    end else begin
      nim = sh_im[BW-1:0];
    end
  end

  // round to integer and clamp for the result word
  always_comb begin
    os_re = (OsW'(re_q) + OsHalf) >>> FracBits;
    os_im = (OsW'(im_q) + OsHalf) >>> FracBits;
    oc_re = (os_re > OsMax) ? OsMax : ((os_re < OsMin) ? OsMin : os_re);
    oc_im = (os_im > OsMax) ? OsMax : ((os_im < OsMin) ? OsMin : os_im);
    trk   = (32'(cfg_i.tracked_bin) >= Bins) ? KW'(Bins - 1) : KW'(cfg_i.tracked_bin);
    sel_out = s4_valid_q && (!cfg_i.output_mode || (s4_k_q == trk));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= ctrl_i.issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= sel_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_k_q    <= addr_i;
      s2_k_q    <= s1_k_q;
      dh_r_q    <= dr[BW-1:LW];
      dl_r_q    <= dr[LW-1:0];
      dh_i_q    <= bi[BW-1:LW];
      dl_i_q    <= bi[LW-1:0];
      c_q       <= tw_re;
      s_q       <= tw_im;
      s3_k_q    <= s2_k_q;
      p_hrc_q   <= dh_r_q * c_q;
      p_his_q   <= dh_i_q * s_q;
      p_hrs_q   <= dh_r_q * s_q;
      p_hic_q   <= dh_i_q * c_q;
      p_lrc_q   <= $signed({1'b0, dl_r_q}) * c_q;
      p_lis_q   <= $signed({1'b0, dl_i_q}) * s_q;
      p_lrs_q   <= $signed({1'b0, dl_r_q}) * s_q;
      p_lic_q   <= $signed({1'b0, dl_i_q}) * c_q;
      s4_k_q    <= s3_k_q;
      re_q      <= nre;
      im_q      <= nim;
      out_idx_q <= sdft_pkg::IdxBits'(s4_k_q);
      out_re_q  <= sdft_pkg::OutBits'(oc_re);
      out_im_q  <= sdft_pkg::OutBits'(oc_im);
      out_last_q <= cfg_i.output_mode || (s4_k_q == KW'(Bins - 1));
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.bin_index = out_idx_q;
  assign res_o.real_part = out_re_q;
  assign res_o.imag_part = out_im_q;
  assign res_o.last      = out_last_q;

endmodule

// ----- rtl/sliding_dft_bins.sv -----
// Sliding DFT engine: sample ring, bin sequencer and configuration.
// Each accepted sample updates the bins in index order; words leave one per cycle unstalled.
// Bins are rotated one per cycle while the output does not stall, through a single
// read-modify-write pass over the bin memory; a new sample waits until that pass drains.
// Reset and every configuration write start a clearing pass over every entry of the ring
// and bin memories; no sample is accepted until it ends.
module sliding_dft_bins #(
  parameter int Bins       = sdft_pkg::BinsDef,
  parameter int SampleBits = sdft_pkg::SampleBitsDef,
  parameter int FracBits   = sdft_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdft_pkg::AddrBits-1:0]  paddr,
  input  logic [sdft_pkg::DataBits-1:0]  pwdata,
  output logic [sdft_pkg::DataBits-1:0]  prdata,
  output logic                           pready,
  sdft_sample_if.sink                    smp_i,
  sdft_result_if.source                  res_o
);

  localparam int KW     = $clog2(Bins);
  localparam int DiffW  = SampleBits + 1;
  localparam int DeltaW = SampleBits + FracBits + 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [KW-1:0]                idx_q, idx_d, pos_q, pos_d;
  logic signed [SampleBits-1:0] ring_mem [Bins];
  logic signed [SampleBits-1:0] oldest_q, sample_q;
  logic signed [DiffW-1:0]      diff;
  logic signed [DeltaW-1:0]     delta;
  logic                         accept, idx_last, cfg_clear;
  sdft_pkg::cfg_t               cfg;
  sdft_pkg::ctrl_t              ctrl;
  sdft_pkg::status_t            status;

  sdft_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (cfg_clear)
  );

  assign smp_i.ready = (state_q == ST_IDLE) && !status.busy;
  assign accept      = smp_i.valid && smp_i.ready;
  assign idx_last    = (idx_q == KW'(Bins - 1));

  assign ctrl.issue = (state_q == ST_RUN);
  assign ctrl.clear = (state_q == ST_CLEAR);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    unique case (state_q)
      ST_CLEAR: begin
        idx_d = idx_last ? '0 : idx_q + 1'b1;
        if (idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          idx_d   = '0;
          pos_d   = (pos_q == KW'(Bins - 1)) ? '0 : pos_q + 1'b1;
        end
      end
      ST_RUN: begin
        if (status.adv) begin
          idx_d = idx_last ? '0 : idx_q + 1'b1;
          if (idx_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        idx_d   = '0;
      end
    endcase
    if (cfg_clear) begin
      state_d = ST_CLEAR;
      idx_d   = '0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
    end
  end

  // swap the new sample into the ring and fetch the one it replaces
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      ring_mem[idx_q] <= '0;
    end else if (accept) begin
      ring_mem[pos_q] <= smp_i.sample;
      oldest_q        <= ring_mem[pos_q];
      sample_q        <= smp_i.sample;
    end
  end

  assign diff  = DiffW'(sample_q) - DiffW'(oldest_q);
  assign delta = DeltaW'(diff) <<< FracBits;

  sdft_datapath #(
    .Bins       (Bins),
    .SampleBits (SampleBits),
    .FracBits   (FracBits)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .ctrl_i   (ctrl),
    .addr_i   (idx_q),
    .delta_i  (delta),
    .status_o (status),
    .res_o    (res_o)
  );

endmodule

// ----- bench/tb_sliding_dft_bins.sv -----
// Self-checking testbench for the sliding DFT engine with an integer bin predictor.
`timescale 1ns / 100ps

module tb_sliding_dft_bins;

  localparam int     NumBins    = sdft_pkg::BinsDef;
  localparam int     FracBits   = sdft_pkg::FracBitsDef;
  localparam int     SmpBits    = sdft_pkg::SampleBitsDef;
  localparam int     IdxBits    = sdft_pkg::IdxBits;
  localparam int     OutBits    = sdft_pkg::OutBits;
  localparam int     AddrBits   = sdft_pkg::AddrBits;
  localparam int     DataBits   = sdft_pkg::DataBits;
  localparam longint RoundHalf  = longint'(1) << (FracBits - 1);
  localparam longint BinLimit   = longint'(1) << (sdft_pkg::BinBits - 1);
  localparam int     DrainWait  = NumBins + 8;
  localparam int     StallLimit = 4000;

  typedef struct packed {
    logic [IdxBits-1:0] bin_index;
    logic [OutBits-1:0] real_part;
    logic [OutBits-1:0] imag_part;
    logic               last;
  } bin_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;

  sdft_sample_if smp_if ();
  sdft_result_if res_if ();

  sliding_dft_bins dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .smp_i   (smp_if),
    .res_o   (res_if)
  );

  always #5 clk_i = ~clk_i;

  logic signed [SmpBits-1:0] pending_samples[$];
  bin_word_t                 expected_bins[$];

  longint             window_ring[NumBins];
  int                 oldest_pos;
  longint             spec_re[NumBins];
  longint             spec_im[NumBins];
  longint             twiddle_re[NumBins];
  longint             twiddle_im[NumBins];
  logic               cfg_mode;
  logic [IdxBits-1:0] cfg_tracked;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int samples_sent   = 0;
  int words_checked  = 0;
  int settings_used  = 1;
  int quiet_cycles   = 0;

  function automatic void q30_sincos(input longint x, output longint c, output longint s);
    longint x2, tc, ts;
    x2 = (x * x) >>> 30;
    tc = longint'(1) << 30;
    ts = x;
    c  = tc;
    s  = ts;
    for (longint i = 1; i <= 7; i++) begin
      tc = ((tc * x2) >>> 30) / ((2 * i - 1) * (2 * i));
      ts = ((ts * x2) >>> 30) / ((2 * i) * (2 * i + 1));
      if (i[0]) begin
        c -= tc;
        s -= ts;
      end else begin
        c += tc;
        s += ts;
      end
    end
  endfunction

  function automatic longint q30_to_frac(input longint v);
    if (v < 0) v = 0;
    return (v + (longint'(1) << (29 - FracBits))) >>> (30 - FracBits);
  endfunction

  function automatic void build_twiddles();
    longint r, q, rem, a, c0, s0, cr, sr, cs, sn;
    for (int k = 0; k < NumBins; k++) begin
      r   = 4 * k;
      q   = r / NumBins;
      rem = r - q * NumBins;
      if (2 * rem <= NumBins) begin
        a = (sdft_pkg::HalfPiQ30 * rem) / NumBins;
        q30_sincos(a, c0, s0);
      end else begin
        a = (sdft_pkg::HalfPiQ30 * (NumBins - rem)) / NumBins;
        q30_sincos(a, s0, c0);
      end
      cr = q30_to_frac(c0);
      sr = q30_to_frac(s0);
      case (q & 3)
        0: begin
          cs = cr;
          sn = sr;
        end
        1: begin
          cs = -sr;
          sn = cr;
        end
        2: begin
          cs = -cr;
          sn = -sr;
        end
        default: begin
          cs = sr;
          sn = -cr;
        end
      endcase
      twiddle_re[k] = cs;
      twiddle_im[k] = -sn;
    end
  endfunction

  function automatic longint sat_bin(input longint x);
    if (x < -BinLimit) return -BinLimit;
    if (x > BinLimit - 1) return BinLimit - 1;
    return x;
  endfunction

  function automatic longint rotate_round(input longint d1, input longint c1,
                                          input longint d2, input longint c2);
    return sat_bin((d1 * c1 + d2 * c2 + RoundHalf) >>> FracBits);
  endfunction

  function automatic logic [OutBits-1:0] bin_to_word(input longint b);
    longint v;
    v = (b + RoundHalf) >>> FracBits;
    if (v < -longint'(sdft_pkg::OutLimit)) v = -longint'(sdft_pkg::OutLimit);
    if (v > longint'(sdft_pkg::OutLimit)) v = longint'(sdft_pkg::OutLimit);
    return v[OutBits-1:0];
  endfunction

  function automatic void clear_window();
    for (int k = 0; k < NumBins; k++) begin
      window_ring[k] = 0;
      spec_re[k]     = 0;
      spec_im[k]     = 0;
    end
    oldest_pos = 0;
  endfunction

  function automatic void push_bin(input int k, input logic is_last);
    bin_word_t w;
    w.bin_index = k[IdxBits-1:0];
    w.real_part = bin_to_word(spec_re[k]);
    w.imag_part = bin_to_word(spec_im[k]);
    w.last      = is_last;
    expected_bins.push_back(w);
  endfunction

  function automatic void advance_window(input logic signed [SmpBits-1:0] smp);
    longint s_val, oldest, delta, dr, di;
    s_val                   = smp;
    oldest                  = window_ring[oldest_pos];
    window_ring[oldest_pos] = s_val;
    oldest_pos              = (oldest_pos + 1) % NumBins;
    delta                   = (s_val - oldest) * (longint'(1) << FracBits);
    for (int k = 0; k < NumBins; k++) begin
      dr = sat_bin(spec_re[k] + delta);
      di = spec_im[k];
      spec_re[k] = rotate_round(dr, twiddle_re[k], di, -twiddle_im[k]);
      spec_im[k] = rotate_round(dr, twiddle_im[k], di, twiddle_re[k]);
    end
    if (cfg_mode) begin
      push_bin((int'(cfg_tracked) >= NumBins) ? NumBins - 1 : int'(cfg_tracked), 1'b1);
    end else begin
      for (int k = 0; k < NumBins; k++) push_bin(k, k == NumBins - 1);
    end
  endfunction

  function automatic void check_bin_word();
    bin_word_t exp_w;
    if (expected_bins.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word bin=%0d re=%0d im=%0d last=%0b", $time,
               res_if.bin_index, res_if.real_part, res_if.imag_part, res_if.last);
      return;
    end
    exp_w = expected_bins.pop_front();
    words_checked++;
    if (res_if.bin_index !== exp_w.bin_index) begin
      mismatches++;
      $display("%0t: bin_index expected %0d actual %0d", $time, exp_w.bin_index,
               res_if.bin_index);
    end
    if (res_if.real_part !== exp_w.real_part) begin
      mismatches++;
      $display("%0t: bin %0d real_part expected %0d actual %0d", $time, exp_w.bin_index,
               $signed(exp_w.real_part), res_if.real_part);
    end
    if (res_if.imag_part !== exp_w.imag_part) begin
      mismatches++;
      $display("%0t: bin %0d imag_part expected %0d actual %0d", $time, exp_w.bin_index,
               $signed(exp_w.imag_part), res_if.imag_part);
    end
    if (res_if.last !== exp_w.last) begin
      mismatches++;
      $display("%0t: bin %0d last expected %0b actual %0b", $time, exp_w.bin_index,
               exp_w.last, res_if.last);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        advance_window(pending_samples.pop_front());
        samples_sent++;
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          smp_if.valid  <= 1'b1;
          smp_if.sample <= pending_samples[0];
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) check_bin_word();
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d words still expected", $time,
               quiet_cycles, expected_bins.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input sdft_pkg::reg_idx_e idx, input logic wr,
                            input logic [DataBits-1:0] wdata,
                            output logic [DataBits-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrBits'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input sdft_pkg::reg_idx_e idx, input logic [DataBits-1:0] value);
    logic [DataBits-1:0] mask, wdata, rdata;
    mask  = (idx == sdft_pkg::REG_OUTPUT_MODE) ? DataBits'(1)
                                               : DataBits'((1 << IdxBits) - 1);
    wdata = ($urandom() & ~mask) | (value & mask);
    apb_access(idx, 1'b1, wdata, rdata);
    if (idx == sdft_pkg::REG_OUTPUT_MODE) cfg_mode = wdata[0];
    else cfg_tracked = wdata[IdxBits-1:0];
    clear_window();
    settings_used++;
    apb_access(idx, 1'b0, '0, rdata);
    if (rdata !== (wdata & mask)) begin
      mismatches++;
      $display("%0t: register %s readback expected %0h actual %0h", $time, idx.name(),
               wdata & mask, rdata);
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_bins.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic queue_random_samples(input int count);
    int kind, len, amp, period;
    logic signed [SmpBits-1:0] level;
    while (count > 0) begin
      kind = $urandom_range(3);
      case (kind)
        0: len = $urandom_range(1, 12);
        1: len = $urandom_range(NumBins, NumBins + 6);
        2: len = $urandom_range(16, 40);
        default: len = $urandom_range(1, 12);
      endcase
      if (len > count) len = count;
      level  = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      amp    = $urandom_range(1, 32767);
      period = $urandom_range(2, 16);
      for (int n = 0; n < len; n++) begin
        case (kind)
          0: pending_samples.push_back(SmpBits'($urandom_range(65535)));
          1: pending_samples.push_back(level);
          2: pending_samples.push_back(SmpBits'(((n % period) < period / 2) ? amp : -amp));
          default: pending_samples.push_back(SmpBits'($urandom_range(15) - 8));
        endcase
      end
      count -= len;
    end
  endtask

  initial begin
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    res_if.ready  = 1'b0;
    cfg_mode      = 1'b0;
    cfg_tracked   = '0;
    build_twiddles();
    clear_window();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_samples.delete();
    pending_samples = '{16'sh0000, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000,
                        16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh0000,
                        16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh00ff, 16'shff00, 16'sh1234, 16'shedcc};
    wait_drained();

    send_idle_pct = 76;
    write_reg(sdft_pkg::REG_TRACKED_BIN, NumBins - 1);
    write_reg(sdft_pkg::REG_OUTPUT_MODE, 1);
    queue_random_samples(70);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 76;
    write_reg(sdft_pkg::REG_OUTPUT_MODE, 0);
    queue_random_samples(60);
    wait_drained();

    send_idle_pct  = 6;
    recv_stall_pct = 6;
    write_reg(sdft_pkg::REG_TRACKED_BIN, $urandom_range(1, NumBins - 2));
    write_reg(sdft_pkg::REG_OUTPUT_MODE, 1);
    queue_random_samples(70);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(sdft_pkg::REG_TRACKED_BIN, 0);
    queue_random_samples(40);
    wait_drained();

    $display("Sent %0d samples across %0d register settings, both output modes.",
             samples_sent, settings_used);
    $display("Checked %0d bin words under no, sender, receiver and mixed idling.",
             words_checked);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
